[rtl/hfrs_pkg.sv]
// Shared types, codes and constants of the HRRN/FIFO ready scheduler.
package hfrs_pkg;

  localparam int SLOTS      = 16;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int WAIT_W     = 32;
  localparam int STAMP_W    = 32;
  localparam int EST_W      = 16;
  localparam int ALPHA_W    = 9;
  localparam int TIME_W     = 16;
  localparam int PADDR_W    = 4;
  localparam int PDATA_W    = 32;
  localparam int PROD_W     = WAIT_W + 1 + EST_W;
  localparam int MIX_W      = ALPHA_W + EST_W + 1;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE  = ALPHA_W'(256);
  localparam logic [ALPHA_W-1:0] ALPHA_RST  = ALPHA_W'(128);
  localparam logic [EST_W-1:0]   EST_INIT   = EST_W'(10000);
  localparam logic [EST_W-1:0]   EST_MIN    = EST_W'(1);
  localparam logic [WAIT_W-1:0]  WAIT_MAX   = {WAIT_W{1'b1}};
  localparam logic [MIX_W-1:0]   MIX_ROUND  = MIX_W'(128);

  typedef enum logic [1:0] {
    KIND_TICK     = 2'd0,
    KIND_ADMIT    = 2'd1,
    KIND_DISPATCH = 2'd2,
    KIND_UPDATE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ALREADY = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_BUSY    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_MODE  = 2'd0,
    REG_ALPHA = 2'd1,
    REG_INIT  = 2'd2,
    REG_NONE  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [SLOT_W-1:0] slot;
    logic              new_process;
    logic [TIME_W-1:0] measured_time;
  } in_item_t;

  typedef struct packed {
    logic              granted;
    logic [SLOT_W-1:0] granted_slot;
    logic [EST_W-1:0]  estimate_out;
    logic [1:0]        status;
  } out_item_t;

  typedef struct packed {
    logic load_item;
    logic scan_clr;
    logic scan_en;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_is_dispatch;
    logic scan_done;
  } dp_stat_t;

endpackage

[rtl/hrrn_fifo_ready_scheduler_unit.sv]
// Top level of the HRRN/FIFO ready scheduler: controller plus datapath.
// Tick, admit and update go from the accepted item straight to the execute
// state and the registered result; dispatch first scans all SLOTS = 16 slots,
// one slot per cycle, through the single cross-multiply ratio comparator.
// One transaction is in flight at a time (dispatch included); the next is
// taken once the result is registered, while that result may still wait.
// Reset (rst_n low, synchronous): ready flags clear, estimates one, stamp zero,
// registers to FIFO mode, alpha 128, initial estimate 10000.
module hrrn_fifo_ready_scheduler_unit import hfrs_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_item_t            in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output out_item_t           out_item,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  // Command and status between sequencer and datapath.
  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Controller: idle -> scan (dispatch only) -> execute, commit when the
  // output register is free.
  hfrs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: slot table, ratio scan, estimate averaging, register file.
  hfrs_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .out_item (out_item),
    .cmd      (cmd),
    .stat     (stat),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

endmodule

[rtl/hfrs_ctrl.sv]
// Controller state machine: sequences accept, slot scan and commit.
module hfrs_ctrl import hfrs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_stat_t   stat,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EXEC = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          if (stat.in_is_dispatch) begin
            cmd.scan_clr = 1'b1;
            state_nxt    = S_SCAN;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (stat.scan_done) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/hfrs_datapath.sv]
// Datapath: slot table, ratio compare, estimate average, registers, result.
module hfrs_datapath import hfrs_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  in_item_t            in_item,
  output out_item_t           out_item,
  input  ctrl_cmd_t           cmd,
  output dp_stat_t            stat,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  logic                  ready_r [SLOTS];
  logic [WAIT_W-1:0]     wait_r  [SLOTS];
  logic [EST_W-1:0]      est_r   [SLOTS];
  logic [STAMP_W-1:0]    stamp_r [SLOTS];
  logic [STAMP_W-1:0]    next_stamp_r;

  logic                  mode_r;
  logic [ALPHA_W-1:0]    alpha_r;
  logic [EST_W-1:0]      init_r;

  in_item_t              item_r;
  out_item_t             out_r;
  logic [SLOT_W-1:0]     scan_idx_r;
  logic                  found_r;
  logic [SLOT_W-1:0]     best_idx_r;
  logic [WAIT_W:0]       best_w1_r;
  logic [EST_W-1:0]      best_est_r;
  logic [STAMP_W-1:0]    best_age_r;

  logic [SLOT_W-1:0]     rd_idx;
  logic [WAIT_W:0]       cand_w1;
  logic [EST_W-1:0]      cand_est;
  logic [STAMP_W-1:0]    cand_age;
  logic [PROD_W-1:0]     prod_cand, prod_best;
  logic                  better;
  logic [ALPHA_W-1:0]    alpha_eff;
  logic [EST_W-1:0]      init_eff;
  logic [MIX_W-1:0]      mix_sum;
  logic [EST_W-1:0]      upd_est;
  logic                  is_disp;
  reg_idx_t              widx;
  logic                  cfg_wr;
  out_item_t             res;

  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[3:2]);
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    case (widx)
      REG_MODE:  prdata = PDATA_W'(mode_r);
      REG_ALPHA: prdata = PDATA_W'(alpha_r);
      REG_INIT:  prdata = PDATA_W'(init_r);
      default:   prdata = '0;
    endcase
  end

  assign is_disp             = (item_r.kind == KIND_DISPATCH);
  assign stat.in_is_dispatch = (in_item.kind == KIND_DISPATCH);
  assign stat.scan_done      = (scan_idx_r == SLOT_W'(SLOTS - 1));

  // One shared read port into the slot table.
  always_comb begin
    if (is_disp) rd_idx = cmd.scan_en ? scan_idx_r : best_idx_r;
    else         rd_idx = item_r.slot;
  end

  assign cand_w1   = {1'b0, wait_r[rd_idx]} + (WAIT_W+1)'(1);
  assign cand_est  = est_r[rd_idx];
  assign cand_age  = next_stamp_r - stamp_r[rd_idx];
  assign prod_cand = PROD_W'(cand_w1 * best_est_r);
  assign prod_best = PROD_W'(best_w1_r * cand_est);

  always_comb begin
    if (!found_r)     better = 1'b1;
    else if (mode_r)  better = (prod_cand > prod_best) ||
                               ((prod_cand == prod_best) && (cand_age > best_age_r));
    else              better = (cand_age > best_age_r);
  end

  // Exponential average: (a*m + (256-a)*e + 128) >> 8, at least one.
  assign alpha_eff = (alpha_r > ALPHA_ONE) ? ALPHA_ONE : alpha_r;
  assign init_eff  = (init_r == '0) ? EST_MIN : init_r;
  assign mix_sum   = MIX_W'(alpha_eff * item_r.measured_time)
                   + MIX_W'((ALPHA_ONE - alpha_eff) * cand_est) + MIX_ROUND;
  always_comb begin
    upd_est = mix_sum[EST_W+7:8];
    if (upd_est == '0) upd_est = EST_MIN;
  end

  always_comb begin
    res = '0;
    case (kind_t'(item_r.kind))
      KIND_TICK: res.estimate_out = cand_est;
      KIND_ADMIT: begin
        if (ready_r[rd_idx]) begin
          res.status       = ST_ALREADY;
          res.estimate_out = cand_est;
        end else begin
          res.estimate_out = item_r.new_process ? init_eff : cand_est;
        end
      end
      KIND_DISPATCH: begin
        if (found_r) begin
          res.granted      = 1'b1;
          res.granted_slot = best_idx_r;
          res.estimate_out = cand_est;
        end else begin
          res.status = ST_EMPTY;
        end
      end
      KIND_UPDATE: begin
        if (ready_r[rd_idx]) begin
          res.status       = ST_BUSY;
          res.estimate_out = cand_est;
        end else begin
          res.estimate_out = upd_est;
        end
      end
      default: res = '0;
    endcase
  end

  assign out_item = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= 1'b0;
      alpha_r      <= ALPHA_RST;
      init_r       <= EST_INIT;
      next_stamp_r <= '0;
      found_r      <= 1'b0;
      scan_idx_r   <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        ready_r[i] <= 1'b0;
        est_r[i]   <= EST_MIN;
      end
    end else begin
      if (cfg_wr) begin
        case (widx)
          REG_MODE:  mode_r  <= pwdata[0];
          REG_ALPHA: alpha_r <= pwdata[ALPHA_W-1:0];
          REG_INIT:  init_r  <= pwdata[EST_W-1:0];
          default:   ;
        endcase
      end
      if (cmd.scan_clr) begin
        scan_idx_r <= '0;
        found_r    <= 1'b0;
      end
      if (cmd.scan_en) begin
        scan_idx_r <= scan_idx_r + SLOT_W'(1);
        if (ready_r[rd_idx] && better) begin
          found_r    <= 1'b1;
          best_idx_r <= rd_idx;
          best_w1_r  <= cand_w1;
          best_est_r <= cand_est;
          best_age_r <= cand_age;
        end
      end
      if (cmd.commit) begin
        out_r <= res;
        case (kind_t'(item_r.kind))
          KIND_TICK: begin
            for (int i = 0; i < SLOTS; i++)
              if (ready_r[i] && wait_r[i] != WAIT_MAX) wait_r[i] <= wait_r[i] + WAIT_W'(1);
          end
          KIND_ADMIT: begin
            if (!ready_r[rd_idx]) begin
              ready_r[rd_idx] <= 1'b1;
              wait_r[rd_idx]  <= '0;
              stamp_r[rd_idx] <= next_stamp_r;
              next_stamp_r    <= next_stamp_r + STAMP_W'(1);
              if (item_r.new_process) est_r[rd_idx] <= init_eff;
            end
          end
          KIND_DISPATCH: begin
            if (found_r) ready_r[best_idx_r] <= 1'b0;
          end
          KIND_UPDATE: begin
            if (!ready_r[rd_idx]) est_r[rd_idx] <= upd_est;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) item_r <= in_item;
  end

endmodule

[rtl/hfrs_checker.sv]
// Port-level checker for the scheduler, bound to the top level.
module hfrs_checker import hfrs_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result dropped while stalled");

  a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.granted |-> out_item.status == ST_OK)
    else $error("grant with error status");

  a_nogrant_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.granted |-> out_item.granted_slot == '0)
    else $error("slot reported without grant");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == ST_EMPTY |-> out_item.estimate_out == '0)
    else $error("estimate on empty dispatch");

endmodule

bind hrrn_fifo_ready_scheduler_unit hfrs_checker u_chk (.*);
